/* rtl/assert_macros.svh */
// Assertion macros shared by the deframer RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SFD_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("deframer assertion failed");

// Next-cycle implication, disabled in reset.
`define SFD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("deframer assertion failed");

`endif

/* rtl/sfd_pkg.sv */
// Types and constants for the sensor frame deframer.
// No dependencies; used by the channel interfaces and the top level.
package sfd_pkg;

   localparam int ByteWidth   = 8;
   localparam int LenWidth    = 16;
   localparam int WordWidth   = 16;
   localparam int NumWidth    = 10;
   localparam int KindWidth   = 2;
   localparam int CodeWidth   = 3;

   localparam logic [ByteWidth-1:0] SyncByte   = 8'hFF;
   localparam logic [LenWidth-1:0]  LimitReset = 16'd2048;

   typedef enum logic [KindWidth-1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_GOOD   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [CodeWidth-1:0] {
      ERR_NONE = 3'd0,
      ERR_SYNC = 3'd1,
      ERR_TYPE = 3'd2,
      ERR_LONG = 3'd3,
      ERR_SUM  = 3'd4
   } err_type;

   typedef struct packed {
      kind_type              kind;
      logic [WordWidth-1:0]  word;
      logic [NumWidth-1:0]   number;
      logic                  ftype;
      err_type               code;
   } rsp_type;

endpackage

/* rtl/sfd_channels.sv */
// Valid/ready channel interfaces for the deframer: byte in, result out, csr write.
// Depends on sfd_pkg for field widths.
interface sfd_req_if;
   logic                         valid;
   logic                         ready;
   logic [sfd_pkg::ByteWidth-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfd_pkg::KindWidth-1:0] result_kind;
   logic [sfd_pkg::WordWidth-1:0] sample_word;
   logic [sfd_pkg::NumWidth-1:0]  sample_number;
   logic                          frame_type;
   logic [sfd_pkg::CodeWidth-1:0] error_code;
   modport source (output valid, output result_kind, output sample_word,
                   output sample_number, output frame_type, output error_code,
                   input ready);
   modport sink   (input valid, input result_kind, input sample_word,
                   input sample_number, input frame_type, input error_code,
                   output ready);
endinterface

interface sfd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [sfd_pkg::LenWidth-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sensor_frame_deframer.sv */
// Sensor frame deframer: one byte per cycle in unless stalled, at most one result word out per byte.
// Depends on sfd_pkg, sfd_channels.sv and assert_macros.svh.

// Accepts one received byte per clock and parses frames of two 0xFF sync bytes, a
// type byte, a 16-bit length (MSB first), the payload and an inverted-sum checksum.
// Type 0 payload byte pairs come out as 16-bit samples; each frame attempt ends in
// one good or error word. A result is presented in the cycle after its byte is taken,
// from a single output register; a byte is taken whenever that register is empty or
// being read in the same cycle, so the sustained rate is one byte per cycle and a
// stalled result side stops input only while the output register stays full. The
// payload limit register is written through the csr channel, which is always ready.
module sensor_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   sfd_req_if.sink    req_ch,
   sfd_rsp_if.source  rsp_ch,
   sfd_csr_if.sink    csr_ch
);
   import sfd_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [2:0] {
      PH_SYNC1   = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_TYPE    = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_LEN_LO  = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CHECK   = 3'd6
   } phase_type;

   phase_type             phase_ff,   phase_in;
   logic                  type_ff,    type_in;
   logic [LenWidth-1:0]   length_ff,  length_in;
   logic [LenWidth-1:0]   taken_ff,   taken_in;
   logic [ByteWidth-1:0]  high_ff,    high_in;
   logic [ByteWidth-1:0]  sum_ff,     sum_in;
   logic [NumWidth-1:0]   samples_ff, samples_in;
   logic [LenWidth-1:0]   limit_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff,     rsp_in;
   logic                  res_valid;

   logic                  req_accept;
   logic [ByteWidth-1:0]  b;
   logic [ByteWidth-1:0]  sum_add;
   logic [LenWidth-1:0]   len_full;
   logic [LenWidth-1:0]   taken_inc;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign b         = req_ch.rx_byte;
   assign sum_add   = sum_ff + b;
   assign len_full  = {length_ff[LenWidth-1:ByteWidth], b};
   assign taken_inc = taken_ff + 16'd1;

   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      taken_in   = taken_ff;
      high_in    = high_ff;
      sum_in     = sum_ff;
      samples_in = samples_ff;
      res_valid  = 1'b0;
      rsp_in     = '{kind: KIND_ERROR, word: '0, number: '0, ftype: 1'b0, code: ERR_NONE};
      unique case (phase_ff)
         PH_SYNC2: begin
            if (b != SyncByte) begin
               phase_in    = PH_SYNC1;
               res_valid   = 1'b1;
               rsp_in.code = ERR_SYNC;
            end else begin
               sum_in   = sum_add;
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (b > 8'd1) begin
               phase_in    = PH_SYNC1;
               res_valid   = 1'b1;
               rsp_in.code = ERR_TYPE;
            end else begin
               type_in  = b[0];
               sum_in   = sum_add;
               phase_in = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            length_in = {b, 8'd0};
            sum_in    = sum_add;
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = len_full;
            sum_in    = sum_add;
            if (len_full >= limit_ff) begin
               phase_in     = PH_SYNC1;
               res_valid    = 1'b1;
               rsp_in.ftype = type_ff;
               rsp_in.code  = ERR_LONG;
            end else begin
               taken_in   = '0;
               samples_in = '0;
               phase_in   = (len_full == '0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_in = sum_add;
            if (!type_ff) begin
               if (!taken_ff[0]) begin
                  high_in = b;
               end else begin
                  res_valid     = 1'b1;
                  rsp_in.kind   = KIND_SAMPLE;
                  rsp_in.word   = {high_ff, b};
                  rsp_in.number = samples_ff;
                  samples_in    = samples_ff + 10'd1;
               end
            end
            taken_in = taken_inc;
            if (taken_inc >= length_ff) phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            phase_in      = PH_SYNC1;
            res_valid     = 1'b1;
            rsp_in.number = samples_ff;
            rsp_in.ftype  = type_ff;
            if (~sum_ff == b) begin
               rsp_in.kind = KIND_GOOD;
            end else begin
               rsp_in.code = ERR_SUM;
            end
         end
         default: begin
            // first sync byte, and any unused phase code
            phase_in = PH_SYNC1;
            if (b != SyncByte) begin
               res_valid   = 1'b1;
               rsp_in.code = ERR_SYNC;
            end else begin
               sum_in     = b;
               type_in    = 1'b0;
               length_in  = '0;
               taken_in   = '0;
               samples_in = '0;
               phase_in   = PH_SYNC2;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         type_ff      <= 1'b0;
         length_ff    <= '0;
         taken_ff     <= '0;
         high_ff      <= '0;
         sum_ff       <= '0;
         samples_ff   <= '0;
         limit_ff     <= LimitReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) limit_ff <= csr_ch.data;
         if (req_accept) begin
            phase_ff   <= phase_in;
            type_ff    <= type_in;
            length_ff  <= length_in;
            taken_ff   <= taken_in;
            high_ff    <= high_in;
            sum_ff     <= sum_in;
            samples_ff <= samples_in;
         end
         if (req_ch.ready) rsp_valid_ff <= req_accept && res_valid;
      end
   end

   // payload register, loaded only with a new result word
   always_ff @(posedge clock) begin
      if (req_accept && res_valid) rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_kind   = rsp_ff.kind;
   assign rsp_ch.sample_word   = rsp_ff.word;
   assign rsp_ch.sample_number = rsp_ff.number;
   assign rsp_ch.frame_type    = rsp_ff.ftype;
   assign rsp_ch.error_code    = rsp_ff.code;

   `SFD_ASSERT_NOW(a_stall_blocks_input, clock, reset,
      rsp_valid_ff && !rsp_ch.ready, !req_ch.ready)
   `SFD_ASSERT_NOW(a_sample_fields, clock, reset,
      rsp_valid_ff && rsp_ff.kind == KIND_SAMPLE,
      rsp_ff.code == ERR_NONE && !rsp_ff.ftype)
   `SFD_ASSERT_NOW(a_payload_nonempty, clock, reset,
      phase_ff == PH_PAYLOAD, length_ff != '0 && taken_ff < length_ff)
   `SFD_ASSERT_NEXT(a_result_follows_end, clock, reset,
      req_accept && phase_ff == PH_CHECK, rsp_valid_ff && rsp_ff.kind != KIND_SAMPLE)
endmodule

/* sim/sfd_frame_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the sensor frame deframer: tracks the parser state from the
// accepted input bytes and compares every result word, field by field.
// Depends on sfd_pkg and the channel interfaces in sfd_channels.sv.
module sfd_frame_checker (
   input  logic clock,
   input  logic reset,
   sfd_req_if   req_ch,
   sfd_rsp_if   rsp_ch,
   sfd_csr_if   csr_ch,
   output int   mismatches,
   output int   outstanding
);
   import sfd_pkg::*;

   typedef enum logic [2:0] {
      HUNT_SYNC1   = 3'd0,
      HUNT_SYNC2   = 3'd1,
      TAKE_TYPE    = 3'd2,
      TAKE_LEN_HI  = 3'd3,
      TAKE_LEN_LO  = 3'd4,
      TAKE_PAYLOAD = 3'd5,
      TAKE_CHECK   = 3'd6
   } parse_phase_type;

   parse_phase_type       phase;
   logic [LenWidth-1:0]   limit;
   logic                  type_bit;
   logic [LenWidth-1:0]   frame_len;
   logic [LenWidth-1:0]   taken;
   logic [ByteWidth-1:0]  high_byte;
   logic [ByteWidth-1:0]  sum;
   logic [NumWidth-1:0]   sample_count;
   rsp_type               expected_results[$];

   // Advance the parser by one byte; queue the result word it causes, if any.
   task automatic parse_byte(input logic [ByteWidth-1:0] b);
      rsp_type r;
      logic    emit;
      r = '0;
      emit = 1'b0;
      case (phase)
         HUNT_SYNC2: begin
            if (b != SyncByte) begin
               phase = HUNT_SYNC1;
               r.kind = KIND_ERROR;
               r.code = ERR_SYNC;
               emit = 1'b1;
            end else begin
               sum = sum + b;
               phase = TAKE_TYPE;
            end
         end
         TAKE_TYPE: begin
            if (b > 8'd1) begin
               phase = HUNT_SYNC1;
               r.kind = KIND_ERROR;
               r.code = ERR_TYPE;
               emit = 1'b1;
            end else begin
               type_bit = b[0];
               sum = sum + b;
               phase = TAKE_LEN_HI;
            end
         end
         TAKE_LEN_HI: begin
            frame_len = {b, 8'h00};
            sum = sum + b;
            phase = TAKE_LEN_LO;
         end
         TAKE_LEN_LO: begin
            frame_len[7:0] = b;
            sum = sum + b;
            if (frame_len >= limit) begin
               phase = HUNT_SYNC1;
               r.kind = KIND_ERROR;
               r.ftype = type_bit;
               r.code = ERR_LONG;
               emit = 1'b1;
            end else begin
               taken = '0;
               sample_count = '0;
               phase = (frame_len == '0) ? TAKE_CHECK : TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            sum = sum + b;
            if (!type_bit) begin
               if (!taken[0]) begin
                  high_byte = b;
               end else begin
                  r.kind = KIND_SAMPLE;
                  r.word = {high_byte, b};
                  r.number = sample_count;
                  emit = 1'b1;
                  sample_count = sample_count + 1'b1;
               end
            end
            taken = taken + 1'b1;
            if (taken >= frame_len) phase = TAKE_CHECK;
         end
         TAKE_CHECK: begin
            phase = HUNT_SYNC1;
            r.number = sample_count;
            r.ftype = type_bit;
            if (~sum == b) begin
               r.kind = KIND_GOOD;
            end else begin
               r.kind = KIND_ERROR;
               r.code = ERR_SUM;
            end
            emit = 1'b1;
         end
         default: begin
            phase = HUNT_SYNC1;
            if (b != SyncByte) begin
               r.kind = KIND_ERROR;
               r.code = ERR_SYNC;
               emit = 1'b1;
            end else begin
               sum = b;
               type_bit = 1'b0;
               frame_len = '0;
               taken = '0;
               sample_count = '0;
               phase = HUNT_SYNC2;
            end
         end
      endcase
      if (emit) expected_results.insert(expected_results.size(), r);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         phase = HUNT_SYNC1;
         limit = LimitReset;
         type_bit = 1'b0;
         frame_len = '0;
         taken = '0;
         high_byte = '0;
         sum = '0;
         sample_count = '0;
         expected_results.delete();
         mismatches = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) limit = csr_ch.data;
         // result side first: a word leaving now belongs to an earlier byte
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected word, expected none, got kind %0d word %h num %0d",
                        $time, rsp_ch.result_kind, rsp_ch.sample_word, rsp_ch.sample_number);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.result_kind !== want.kind) begin
                  $display("%0t: result_kind expected %0d got %0d",
                           $time, want.kind, rsp_ch.result_kind);
                  mismatches++;
               end
               if (rsp_ch.sample_word !== want.word) begin
                  $display("%0t: sample_word expected %h got %h",
                           $time, want.word, rsp_ch.sample_word);
                  mismatches++;
               end
               if (rsp_ch.sample_number !== want.number) begin
                  $display("%0t: sample_number expected %0d got %0d",
                           $time, want.number, rsp_ch.sample_number);
                  mismatches++;
               end
               if (rsp_ch.frame_type !== want.ftype) begin
                  $display("%0t: frame_type expected %0d got %0d",
                           $time, want.ftype, rsp_ch.frame_type);
                  mismatches++;
               end
               if (rsp_ch.error_code !== want.code) begin
                  $display("%0t: error_code expected %0d got %0d",
                           $time, want.code, rsp_ch.error_code);
                  mismatches++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) parse_byte(req_ch.rx_byte);
      end
      outstanding = expected_results.size();
   end

endmodule

/* sim/tb_sensor_frame_deframer.sv */
`timescale 1ns / 1ps
// Top of the sensor frame deframer testbench: clock, reset, byte stimulus,
// limit writes, result-side stalls and the verdict.
// Depends on sfd_pkg, sfd_channels.sv, the deframer RTL and sfd_frame_checker.
module tb_sensor_frame_deframer;
   import sfd_pkg::*;

   localparam int HoldCycles   = 150;
   localparam int QuietLimit   = 2000;
   localparam int PhaseItems   = 60;

   logic clock;
   logic reset;

   sfd_req_if req_ch();
   sfd_rsp_if rsp_ch();
   sfd_csr_if csr_ch();

   int mismatches;
   int outstanding;

   sensor_frame_deframer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sfd_frame_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   logic [LenWidth-1:0]  cur_limit;
   logic [ByteWidth-1:0] payload_bytes[$];
   bit                   hold_off_req;
   int                   burst_left;
   int                   sent_count;
   int                   quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [ByteWidth-1:0] rand_byte();
      case ($urandom_range(0, 15))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Entered and left at a falling edge; valid stays up within a burst.
   task automatic send_byte(input logic [ByteWidth-1:0] b);
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 31);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   endtask

   // Header, then payload and checksum unless the length will be refused.
   // Payload comes from payload_bytes where given, random otherwise.
   task automatic send_frame(input logic ftype, input logic [LenWidth-1:0] len,
                             input bit bad_sum);
      logic [ByteWidth-1:0] sum;
      logic [ByteWidth-1:0] pb;
      // two sync bytes already wrap the sum to 8'hFE
      sum = 8'hFE + {7'd0, ftype} + len[15:8] + len[7:0];
      send_byte(SyncByte);
      send_byte(SyncByte);
      send_byte({7'd0, ftype});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      if (len < cur_limit) begin
         for (int i = 0; i < int'(len); i++) begin
            pb = (i < payload_bytes.size()) ? payload_bytes[i] : rand_byte();
            sum = sum + pb;
            send_byte(pb);
         end
         if (bad_sum) send_byte(~sum ^ 8'($urandom_range(1, 255)));
         else send_byte(~sum);
      end
      payload_bytes.delete();
   endtask

   // Mostly well-formed frames; the rest are noise and broken headers that
   // all leave the parser hunting for sync again.
   task automatic mixed_traffic(input int n);
      int                  start;
      int                  pick;
      int                  len_max;
      logic [LenWidth-1:0] len;
      start = sent_count;
      while (sent_count - start < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            if (cur_limit == '0 || $urandom_range(0, 9) == 0) begin
               len = LenWidth'($urandom_range(int'(cur_limit), 65535));
            end else begin
               len_max = ($urandom_range(0, 9) == 0) ? 64 : 16;
               if (len_max >= int'(cur_limit)) len_max = int'(cur_limit) - 1;
               len = LenWidth'($urandom_range(0, len_max));
            end
            send_frame(($urandom_range(0, 9) < 7) ? 1'b0 : 1'b1, len,
                       $urandom_range(0, 7) == 0);
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
         end else if (pick < 91) begin
            send_byte(SyncByte);
            send_byte(8'($urandom_range(0, 254)));
         end else begin
            send_byte(SyncByte);
            send_byte(SyncByte);
            send_byte(8'($urandom_range(2, 255)));
         end
      end
   endtask

   // Stop sending and let every expected word drain, then wait out any
   // byte still in flight that causes no word.
   task automatic settle();
      req_ch.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LenWidth-1:0] value);
      settle();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      cur_limit = value;
   endtask

   // Result side: own stall pattern, plus one long hold-off on request.
   initial begin
      int tick;
      tick = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            case ((tick / 97) % 3)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= (tick % 6) < 4;
               default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [LenWidth-1:0] limits[5];
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      hold_off_req = 1'b0;
      burst_left = 0;
      sent_count = 0;
      quiet_cycles = 0;
      cur_limit = LimitReset;
      limits = '{16'd0, 16'd1, 16'hFFFF, 16'd0, LimitReset};
      limits[3] = LenWidth'($urandom_range(2, 40));
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // samples 0xFF00 and 0x00FF, then an unpaired trailing byte
      payload_bytes = {8'hFF, 8'h00, 8'h00, 8'hFF, 8'hA5};
      send_frame(1'b0, 16'd5, 1'b0);
      payload_bytes = {8'h3C};
      send_frame(1'b1, 16'd1, 1'b1);
      send_byte(8'h00);
      send_byte(SyncByte);
      send_byte(8'h7E);
      send_byte(SyncByte);
      send_byte(SyncByte);
      send_byte(8'h02);
      send_frame(1'b1, 16'hFFFF, 1'b0);
      send_frame(1'b0, LimitReset, 1'b0);

      // result side holds off while a sample frame keeps coming
      hold_off_req = 1'b1;
      send_frame(1'b0, 16'd16, 1'b0);

      mixed_traffic(PhaseItems);
      foreach (limits[i]) begin
         write_limit(limits[i]);
         mixed_traffic(PhaseItems);
      end

      settle();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_channels.sv
rtl/sensor_frame_deframer.sv
sim/sfd_frame_checker.sv
sim/tb_sensor_frame_deframer.sv
